// ===== hw/rtl/kss_pkg.sv =====
`timescale 1ns / 1ps

package kss_pkg;

   // Number of key and data pairs the stack holds.
   localparam int DEPTH = 16;

   // Entry count runs from 0 to DEPTH inclusive; the address covers 0 to DEPTH-1.
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/keyed_stack_with_search.sv =====
`timescale 1ns / 1ps

// Keyed stack with search. A bounded last-in-first-out store of up to
// kss_pkg::DEPTH key and data pairs held in one synchronous memory with a top
// count. A push request writes the pair on top, a pop request drops the top
// entry, and a find request walks the stored entries from the newest to the
// oldest and returns the data of the first one whose key matches. Every
// request yields exactly one response that carries the entry count after the
// operation and an empty flag. A pop on an empty store reports status 1 and a
// push on a full store is dropped with status 2; request kind 3 does nothing.
// Push, pop and the unused kind pass from acceptance through the done state
// into the output register. A find issues one memory read per cycle and
// compares each read word while the next read is issued, stopping at the
// first match from the top or after all stored entries; the single read
// port of the memory sets this pace. One request is worked on at a
// time; a new request is taken once the previous response has been moved into
// the output register, even while that response still waits to be taken.

module keyed_stack_with_search (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [kss_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [kss_pkg::KEY_W-1:0]      req_entry_key,
   input  logic signed [kss_pkg::VALUE_W-1:0]    req_entry_value,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic signed [kss_pkg::VALUE_W-1:0]    rsp_found_value,
   output logic [kss_pkg::COUNT_W-1:0]           rsp_entry_count,
   output logic                                  rsp_is_empty,
   output logic [kss_pkg::STAT_W-1:0]            rsp_status
);

   localparam int CNT_W   = kss_pkg::CNT_W;
   localparam int ADDR_W  = kss_pkg::ADDR_W;
   localparam int KEY_W   = kss_pkg::KEY_W;
   localparam int VALUE_W = kss_pkg::VALUE_W;
   localparam int ENTRY_W = KEY_W + VALUE_W;

   // Each memory word holds the key in the upper half and the data below it.
   logic [ENTRY_W-1:0] mem [kss_pkg::DEPTH];

   kss_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      res_hit_ff, res_hit_in;
   logic [VALUE_W-1:0]        res_found_ff, res_found_in;
   logic [kss_pkg::STAT_W-1:0] res_status_ff, res_status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]         rsp_found_ff, rsp_found_in;
   logic [kss_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic [kss_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [ENTRY_W-1:0]   mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [ENTRY_W-1:0]   mem_rdata_ff;

   logic                     req_fire;
   logic                     out_free;
   logic                     is_full;
   logic                     is_zero;
   logic [CNT_W-1:0]         count_m1;
   logic [CNT_W+kss_pkg::COUNT_W-1:0] count_ext;
   logic                     key_match;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (count_ff >= CNT_W'(kss_pkg::DEPTH));
   assign is_zero   = (count_ff == '0);
   assign count_m1  = count_ff - CNT_W'(1);
   // The reported count is the stored count masked to the response width.
   assign count_ext = {{kss_pkg::COUNT_W{1'b0}}, count_ff};
   assign key_match = (mem_rdata_ff[ENTRY_W-1:VALUE_W] == key_ff);

   // Single write port and single registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kss_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      res_hit_ff    <= res_hit_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      remain_in     = remain_ff;
      rd_valid_in   = 1'b0;
      res_hit_in    = res_hit_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;

      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[ADDR_W-1:0];
      mem_wdata     = {req_entry_key, req_entry_value};
      mem_re        = 1'b0;
      mem_raddr     = addr_ff;

      unique case (state_ff)
         kss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               key_in        = req_entry_key;
               res_hit_in    = 1'b0;
               res_found_in  = '0;
               res_status_in = kss_pkg::ST_OK;
               state_in      = kss_pkg::ST_DONE;
               unique case (req_kind)
                  kss_pkg::KIND_PUSH: begin
                     if (is_full) begin
                        res_status_in = kss_pkg::ST_PUSH_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  kss_pkg::KIND_POP: begin
                     if (is_zero) begin
                        res_status_in = kss_pkg::ST_POP_EMPTY;
                     end else begin
                        count_in = count_m1;
                     end
                  end
                  kss_pkg::KIND_FIND: begin
                     // An empty store misses at once; otherwise scan from the top.
                     if (!is_zero) begin
                        addr_in   = count_m1[ADDR_W-1:0];
                        remain_in = count_ff;
                        state_in  = kss_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         kss_pkg::ST_SCAN: begin
            // Reads are issued one per cycle while the previous read is compared.
            if (rd_valid_ff && key_match) begin
               res_hit_in   = 1'b1;
               res_found_in = mem_rdata_ff[VALUE_W-1:0];
               state_in     = kss_pkg::ST_DONE;
            end else if (remain_ff == '0) begin
               if (rd_valid_ff) begin
                  state_in = kss_pkg::ST_DONE;
               end
            end else begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               addr_in     = addr_ff - ADDR_W'(1);
               remain_in   = remain_ff - CNT_W'(1);
            end
         end

         kss_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = count_ext[kss_pkg::COUNT_W-1:0];
               rsp_empty_in  = is_zero;
               rsp_status_in = res_status_ff;
               state_in      = kss_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kss_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
